FILE: rtl/core/cmg_pkg.sv
// Package: shared types, constants and table builder for the cylinder mesh generator.
`timescale 1ns / 1ps
package cmg_pkg;

  localparam int SINE_BITS   = 10;
  localparam int SINE_N      = 1 << SINE_BITS;
  localparam int PHASE_BITS  = SINE_BITS + 2;
  localparam int ADDR_BITS   = SINE_BITS + 1;
  localparam int QUO_BITS    = 17;               // i*2^16/count, i <= count
  localparam int REM_BITS    = 25;
  localparam int IDX_BITS    = 3;
  localparam int QUAD_BEATS  = 6;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  typedef enum logic [IDX_BITS-1:0] {
    REG_RADIUS_BASE = 3'd0,
    REG_RADIUS_TOP  = 3'd1,
    REG_CYL_HEIGHT  = 3'd2,
    REG_BASE_Y      = 3'd3,
    REG_SLICE_COUNT = 3'd4,
    REG_STACK_COUNT = 3'd5
  } reg_idx_t;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_QUAD   = 1'b1;

  typedef logic [15:0] sine_rom_t [0:SINE_N];

  typedef struct packed {
    logic                        op;
    logic                        bad;
    logic [7:0]                  slice;
    logic [7:0]                  stack;
    logic [REM_BITS-1:0]         rem_i;
    logic [REM_BITS-1:0]         rem_j;
    logic [QUO_BITS-1:0]         q_i;
    logic [QUO_BITS-1:0]         q_j;
    logic [15:0]                 fi;
    logic [15:0]                 fj;
    logic [PHASE_BITS-1:0]       phase;
    logic [15:0]                 first;
    logic [15:0]                 second;
    logic [ADDR_BITS-1:0]        addr_s;
    logic [ADDR_BITS-1:0]        addr_c;
    logic                        neg_s;
    logic                        neg_c;
    logic signed [33:0]          prod_a;
    logic signed [33:0]          prod_b;
    logic signed [33:0]          prod_y;
    logic signed [15:0]          rad;
    logic signed [15:0]          pos_y;
    logic signed [33:0]          prod_x;
    logic signed [33:0]          prod_z;
    logic signed [15:0]          pos_x;
    logic signed [15:0]          pos_z;
    logic signed [15:0]          nx;
    logic signed [15:0]          nz;
    logic [15:0]                 tex_u;
    logic [15:0]                 tex_v;
  } pipe_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // long division for table building, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series for round(32768*sin(k*pi/(2N))), elaboration only
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        den;
    logic signed [63:0] sum;
    if (k == 0) begin
      return 16'd0;
    end
    if (k >= SINE_N) begin
      return 16'h8000;
    end
    x    = (64'(k) * HALFPI_Q30) >> SINE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int m = 1; m <= 8; m++) begin
      term = (term * x2) >> 30;
      den  = 64'((2 * m) * (2 * m + 1));
      term = udiv64(term, den);
      if (m[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = $signed(((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30);
    if (sum > 32768) begin
      return 16'h8000;
    end
    return sum[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int k = 0; k <= SINE_N; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  // phase of a full circle -> quarter table address and sign
  function automatic logic [ADDR_BITS:0] phase_addr(input logic [PHASE_BITS-1:0] ph);
    logic [ADDR_BITS-1:0] r;
    logic [ADDR_BITS-1:0] a;
    r = {1'b0, ph[SINE_BITS-1:0]};
    a = ph[SINE_BITS] ? ADDR_BITS'(SINE_N) - r : r;
    return {ph[SINE_BITS+1], a};
  endfunction

endpackage

FILE: rtl/core/cylinder_mesh_generator_unit.sv
// Top level: pipelined cylinder (frustum) mesh vertex and quad index generator.
//
// Input channel (in_valid / in_stall): one transaction carries opcode, slice
// and stack. Opcode vertex yields one result: position, uv and radial normal.
// Opcode quad yields six index results, the sixth flagged last_of_run.
// Requests out of range give a single result with bad_request set.
// Output channel (out_valid / out_stall) is held steady while stalled.
// The pipeline takes one transaction per cycle while nothing stalls; the 17
// restoring divider stages (one quotient bit each) set the depth. A quad
// occupies the output register for its six index results, and a later
// transaction waits until the last of them is taken. Every stage advances
// when it is empty or its successor advances, so bubbles collapse and a
// stalled receiver only backs up as far as needed.
// Config registers are written on cfg_wr_en with cfg_index / cfg_wdata; write
// only while no transaction is in flight. Reset (rst_n low, synchronous)
// empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
module cylinder_mesh_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_slice_idx,
  input  logic [7:0]  in_stack_idx,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_pos_z,
  output logic [15:0] out_tex_u,
  output logic [15:0] out_tex_v,
  output logic [15:0] out_normal_x,
  output logic [15:0] out_normal_z,
  output logic [15:0] out_vertex_index,
  output logic        out_result_kind,
  output logic        out_last_of_run,
  output logic        out_bad_request
);

  localparam int NDIV = cmg_pkg::QUO_BITS;
  localparam cmg_pkg::sine_rom_t SINE_ROM = cmg_pkg::build_sine_rom();

  // ---------------- configuration registers ----------------
  logic signed [15:0] radius_base_r, radius_top_r, cyl_height_r, base_y_r;
  logic [7:0]         slice_count_r, stack_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_base_r <= 16'sd256;
      radius_top_r  <= 16'sd256;
      cyl_height_r  <= 16'sd256;
      base_y_r      <= 16'sd0;
      slice_count_r <= 8'd16;
      stack_count_r <= 8'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cmg_pkg::REG_RADIUS_BASE: radius_base_r <= cfg_wdata;
        cmg_pkg::REG_RADIUS_TOP:  radius_top_r  <= cfg_wdata;
        cmg_pkg::REG_CYL_HEIGHT:  cyl_height_r  <= cfg_wdata;
        cmg_pkg::REG_BASE_Y:      base_y_r      <= cfg_wdata;
        cmg_pkg::REG_SLICE_COUNT: slice_count_r <= cfg_wdata[7:0];
        cmg_pkg::REG_STACK_COUNT: stack_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage valids and ready chain ----------------
  cmg_pkg::pipe_t a_r, f_r, g_r, h_r, m_r, n_r;
  cmg_pkg::pipe_t a_nxt, f_nxt, g_nxt, h_nxt, m_nxt, n_nxt;
  logic a_v_r, f_v_r, g_v_r, h_v_r, m_v_r, n_v_r;
  logic a_rdy, f_rdy, g_rdy, h_rdy, m_rdy, n_rdy, out_rdy;

  cmg_pkg::pipe_t        dv_r   [NDIV];
  cmg_pkg::pipe_t        dv_nxt [NDIV];
  cmg_pkg::pipe_t        dv_src [NDIV];
  logic [NDIV-1:0]       dv_v_r;
  logic [NDIV-1:0]       dv_src_v;
  logic [NDIV-1:0]       dv_rdy;
  logic [NDIV-1:0]       dv_next_rdy;

  // output register
  logic        out_v_r;
  logic [2:0]  beat_r;
  logic        multi_r;
  logic        kind_r, bad_r;
  logic [15:0] first_r, second_r;
  logic [15:0] pos_x_r, pos_y_r, pos_z_r, tex_u_r, tex_v_r, nx_r, nz_r;
  logic        out_done;

  assign out_done = !multi_r || (beat_r == 3'(cmg_pkg::QUAD_BEATS - 1));
  assign out_rdy  = !out_v_r || (!out_stall && out_done);
  assign n_rdy    = !n_v_r || out_rdy;
  assign m_rdy    = !m_v_r || n_rdy;
  assign h_rdy    = !h_v_r || m_rdy;
  assign g_rdy    = !g_v_r || h_rdy;
  assign f_rdy    = !f_v_r || g_rdy;
  assign a_rdy    = !a_v_r || dv_rdy[0];
  assign in_stall = !a_rdy;

  // ---------------- stage A: capture and range check ----------------
  logic counts_ok, bad_in;
  assign counts_ok = (slice_count_r != 8'd0) && (stack_count_r != 8'd0);
  always_comb begin
    if (in_opcode == cmg_pkg::OP_QUAD) begin
      bad_in = !counts_ok || (in_slice_idx >= slice_count_r) ||
               (in_stack_idx >= stack_count_r);
    end else begin
      bad_in = !counts_ok || (in_slice_idx > slice_count_r) ||
               (in_stack_idx > stack_count_r);
    end
    a_nxt       = a_r;
    a_nxt.op    = in_opcode;
    a_nxt.bad   = bad_in;
    a_nxt.slice = in_slice_idx;
    a_nxt.stack = in_stack_idx;
    a_nxt.rem_i = cmg_pkg::REM_BITS'({in_slice_idx, 16'd0});
    a_nxt.rem_j = cmg_pkg::REM_BITS'({in_stack_idx, 16'd0});
    a_nxt.q_i   = '0;
    a_nxt.q_j   = '0;
  end

  // ---------------- divider stages: one quotient bit each ----------------
  assign dv_src[0]   = a_r;
  assign dv_src_v[0] = a_v_r;
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int B = NDIV - 1 - k;
    logic [cmg_pkg::REM_BITS-1:0] dsor_i, dsor_j;

    if (k > 0) begin : g_link
      assign dv_src[k]   = dv_r[k-1];
      assign dv_src_v[k] = dv_v_r[k-1];
    end
    if (k == NDIV - 1) begin : g_tail
      assign dv_next_rdy[k] = f_rdy;
    end else begin : g_mid
      assign dv_next_rdy[k] = dv_rdy[k+1];
    end
    assign dv_rdy[k] = !dv_v_r[k] || dv_next_rdy[k];

    assign dsor_i = cmg_pkg::REM_BITS'(slice_count_r) << B;
    assign dsor_j = cmg_pkg::REM_BITS'(stack_count_r) << B;

    always_comb begin
      dv_nxt[k] = dv_src[k];
      if (dv_src[k].rem_i >= dsor_i) begin
        dv_nxt[k].rem_i  = dv_src[k].rem_i - dsor_i;
        dv_nxt[k].q_i[B] = 1'b1;
      end
      if (dv_src[k].rem_j >= dsor_j) begin
        dv_nxt[k].rem_j  = dv_src[k].rem_j - dsor_j;
        dv_nxt[k].q_j[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (dv_rdy[k]) begin
        dv_v_r[k] <= dv_src_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (dv_rdy[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // ---------------- stage F: fractions, phase, quad corners ----------------
  // q = floor(x*2^16/count): rounded x/count in Q1.15 is (q+1)>>1,
  // rounded phase in 4N units is (q+8)>>4 (wraps to zero at a full turn)
  logic [cmg_pkg::QUO_BITS:0] qi1, qj1, qi8;
  logic [16:0]                first_w;
  always_comb begin
    qi1     = {1'b0, dv_r[NDIV-1].q_i} + 1'b1;
    qj1     = {1'b0, dv_r[NDIV-1].q_j} + 1'b1;
    qi8     = {1'b0, dv_r[NDIV-1].q_i} + 18'd8;
    first_w = 17'(dv_r[NDIV-1].stack) +
              17'({1'b0, stack_count_r} + 9'd1) * 17'(dv_r[NDIV-1].slice);
    f_nxt        = dv_r[NDIV-1];
    f_nxt.fi     = qi1[16:1];
    f_nxt.fj     = qj1[16:1];
    f_nxt.phase  = qi8[cmg_pkg::PHASE_BITS+3:4];
    f_nxt.first  = first_w[15:0];
    f_nxt.second = first_w[15:0] + 16'(stack_count_r) + 16'd1;
  end

  // ---------------- stage G: table addresses, radius products ----------------
  logic [cmg_pkg::ADDR_BITS:0]  sa, ca;
  logic [cmg_pkg::PHASE_BITS-1:0] cph;
  logic [16:0]                  wa;
  always_comb begin
    cph = f_r.phase + cmg_pkg::PHASE_BITS'(cmg_pkg::SINE_N);
    sa  = cmg_pkg::phase_addr(f_r.phase);
    ca  = cmg_pkg::phase_addr(cph);
    wa  = 17'd32768 - {1'b0, f_r.fj};
    g_nxt        = f_r;
    g_nxt.addr_s = sa[cmg_pkg::ADDR_BITS-1:0];
    g_nxt.neg_s  = sa[cmg_pkg::ADDR_BITS];
    g_nxt.addr_c = ca[cmg_pkg::ADDR_BITS-1:0];
    g_nxt.neg_c  = ca[cmg_pkg::ADDR_BITS];
    g_nxt.prod_a = 34'(radius_base_r) * 34'($signed({1'b0, wa}));
    g_nxt.prod_b = 34'(radius_top_r) * 34'($signed({2'b0, f_r.fj}));
    g_nxt.prod_y = 34'(cyl_height_r) * 34'($signed({2'b0, f_r.fj}));
  end

  // ---------------- stage H: sine table read, radius and height ----------------
  logic [15:0]        sin_rd_r, cos_rd_r;
  logic signed [35:0] rad_sum, y_sum;
  always_comb begin
    rad_sum = (36'(g_r.prod_a) + 36'(g_r.prod_b) + 36'sd16384) >>> 15;
    y_sum   = 36'(base_y_r) + ((36'(g_r.prod_y) + 36'sd16384) >>> 15);
    h_nxt       = g_r;
    h_nxt.rad   = cmg_pkg::sat16(rad_sum);
    h_nxt.pos_y = cmg_pkg::sat16(y_sum);
  end

  always_ff @(posedge clk) begin
    if (h_rdy) begin
      sin_rd_r <= SINE_ROM[g_r.addr_s];
      cos_rd_r <= SINE_ROM[g_r.addr_c];
    end
  end

  // ---------------- stage M: signed sine/cosine, position products ----------------
  logic signed [16:0] sin_v, cos_v;
  always_comb begin
    sin_v = h_r.neg_s ? -$signed({1'b0, sin_rd_r}) : $signed({1'b0, sin_rd_r});
    cos_v = h_r.neg_c ? -$signed({1'b0, cos_rd_r}) : $signed({1'b0, cos_rd_r});
    m_nxt        = h_r;
    m_nxt.prod_x = 34'(cos_v) * 34'(h_r.rad);
    m_nxt.prod_z = 34'(sin_v) * 34'(h_r.rad);
    m_nxt.nx     = cmg_pkg::sat16(36'(cos_v));
    m_nxt.nz     = cmg_pkg::sat16(36'(sin_v));
  end

  // ---------------- stage N: rounding and texture coordinates ----------------
  always_comb begin
    n_nxt       = m_r;
    n_nxt.pos_x = cmg_pkg::sat16((36'(m_r.prod_x) + 36'sd16384) >>> 15);
    n_nxt.pos_z = cmg_pkg::sat16((36'(m_r.prod_z) + 36'sd16384) >>> 15);
    n_nxt.tex_u = 16'h8000 - m_r.fi;
    n_nxt.tex_v = 16'h8000 - m_r.fj;
  end

  // ---------------- stage registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      m_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (f_rdy) f_v_r <= dv_v_r[NDIV-1];
      if (g_rdy) g_v_r <= f_v_r;
      if (h_rdy) h_v_r <= g_v_r;
      if (m_rdy) m_v_r <= h_v_r;
      if (n_rdy) n_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) a_r <= a_nxt;
    if (f_rdy) f_r <= f_nxt;
    if (g_rdy) g_r <= g_nxt;
    if (h_rdy) h_r <= h_nxt;
    if (m_rdy) m_r <= m_nxt;
    if (n_rdy) n_r <= n_nxt;
  end

  // ---------------- output register with quad expansion ----------------
  logic vert_ok;
  assign vert_ok = !n_r.bad && (n_r.op == cmg_pkg::OP_VERTEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      beat_r  <= 3'd0;
      multi_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= n_v_r;
      beat_r  <= 3'd0;
      multi_r <= (n_r.op == cmg_pkg::OP_QUAD) && !n_r.bad;
    end else if (!out_stall) begin
      beat_r <= beat_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      kind_r   <= n_r.op;
      bad_r    <= n_r.bad;
      first_r  <= n_r.first;
      second_r <= n_r.second;
      pos_x_r  <= vert_ok ? n_r.pos_x : 16'd0;
      pos_y_r  <= vert_ok ? n_r.pos_y : 16'd0;
      pos_z_r  <= vert_ok ? n_r.pos_z : 16'd0;
      tex_u_r  <= vert_ok ? n_r.tex_u : 16'd0;
      tex_v_r  <= vert_ok ? n_r.tex_v : 16'd0;
      nx_r     <= vert_ok ? n_r.nx    : 16'd0;
      nz_r     <= vert_ok ? n_r.nz    : 16'd0;
    end
  end

  // reversed index order of the quad: f+1, s+1, f, s+1, s, f
  logic [15:0] quad_idx;
  always_comb begin
    case (beat_r)
      3'd0:    quad_idx = first_r + 16'd1;
      3'd1:    quad_idx = second_r + 16'd1;
      3'd2:    quad_idx = first_r;
      3'd3:    quad_idx = second_r + 16'd1;
      3'd4:    quad_idx = second_r;
      default: quad_idx = first_r;
    endcase
  end

  assign out_valid        = out_v_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_tex_u        = tex_u_r;
  assign out_tex_v        = tex_v_r;
  assign out_normal_x     = nx_r;
  assign out_normal_z     = nz_r;
  assign out_vertex_index = multi_r ? quad_idx : 16'd0;
  assign out_result_kind  = kind_r;
  assign out_last_of_run  = out_done;
  assign out_bad_request  = bad_r;

endmodule
